// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the sorted set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle, outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/ssis_pkg.sv =====
// Package with the types, codes and constants of the sorted set block.
`timescale 1ns / 1ps

package ssis_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int VALUE_W      = 32;
   localparam int CMD_W        = 1;
   localparam int STATUS_W     = 2;
   localparam int POS_W        = 6;

   localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_result_type;

endpackage

// ===== src/ssis_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface ssis_req_if;
   logic                                valid;
   logic                                ready;
   logic [ssis_pkg::CMD_W-1:0]          cmd;
   logic signed [ssis_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink (input valid, input cmd, input value, output ready);
endinterface

interface ssis_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssis_pkg::STATUS_W-1:0] status;
   logic [ssis_pkg::POS_W-1:0]    position;
   logic [ssis_pkg::POS_W-1:0]    entry_count;

   modport source (output valid, output status, output position, output entry_count,
                   input ready);
   modport sink (input valid, input status, input position, input entry_count,
                 output ready);
endinterface

// ===== src/ssis_cmp.sv =====
// Shared signed comparator used for every table entry visited by the scan.
`timescale 1ns / 1ps

module ssis_cmp (
   input  logic signed [ssis_pkg::VALUE_W-1:0] entry,
   input  logic signed [ssis_pkg::VALUE_W-1:0] key,
   output ssis_pkg::cmp_result_type             result
);

   always_comb begin
      result.less  = (entry < key);
      result.equal = (entry == key);
   end

endmodule

// ===== src/sorted_set_insert_search.sv =====
// Top level of the sorted set: a table walked by one comparator, with search and insert.
//
// The block keeps up to CAPACITY distinct signed values in ascending order in a table with
// one write port and one registered read port. After a request transfer the sequencer scans
// entries from 0 with one comparator, one entry per cycle, until it reaches the first entry
// that is not smaller than the key or the end of the stored values. A search, a duplicate
// insert or an insert into a full table finishes there and reports its stop position as pos.
// An insert of a new key then moves the entries from pos up by one, one entry per cycle,
// reading one entry and writing the one read before, and writes the key. The response
// waits in an output register; a new request is taken once the block is idle and that
// register is empty. The table needs no clearing after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_set_insert_search #(
   parameter int CAPACITY = ssis_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ssis_req_if.sink   req_chan,
   ssis_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   ssis_pkg::state_type state_ff, state_in;

   logic signed [ssis_pkg::VALUE_W-1:0] key_ff, key_in;
   logic [ssis_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic [CNT_W-1:0]                    pos_ff, pos_in;
   logic [CNT_W-1:0]                    sh_ff, sh_in;
   logic [CNT_W-1:0]                    count_ff, count_in;

   logic [ssis_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [ssis_pkg::VALUE_W-1:0] table_mem [CAPACITY];
   logic signed [ssis_pkg::VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]                    rd_addr;
   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   logic signed [ssis_pkg::VALUE_W-1:0] wr_data;

   ssis_pkg::cmp_result_type cmp_res;

   logic             req_xfer;
   logic             scan_end;
   logic             present;
   logic             full;
   logic             scan_stop;
   logic             do_insert;
   logic             shift_last;
   logic [CNT_W-1:0] pos_next;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W-1:0] sh_dec;
   logic [CNT_W-1:0] sh_dec2;

   ssis_cmp u_cmp (
      .entry  (rd_data_ff),
      .key    (key_ff),
      .result (cmp_res)
   );

   assign req_xfer   = req_chan.valid & req_chan.ready;
   assign scan_end   = (pos_ff == count_ff);
   assign present    = !scan_end && cmp_res.equal;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign scan_stop  = scan_end || !cmp_res.less;
   assign do_insert  = (cmd_ff == ssis_pkg::CMD_INSERT) && !present && !full;
   assign pos_next   = pos_ff + CNT_W'(1);
   assign count_dec  = count_ff - CNT_W'(1);
   assign sh_dec     = sh_ff - CNT_W'(1);
   assign sh_dec2    = sh_ff - CNT_W'(2);
   assign shift_last = (sh_dec == pos_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssis_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = ssis_pkg::ST_SCAN;
            end
         end
         ssis_pkg::ST_SCAN: begin
            if (scan_stop) begin
               if (!do_insert) begin
                  state_in = ssis_pkg::ST_IDLE;
               end else if (scan_end) begin
                  state_in = ssis_pkg::ST_WRITE;
               end else begin
                  state_in = ssis_pkg::ST_SHIFT;
               end
            end
         end
         ssis_pkg::ST_SHIFT: begin
            if (shift_last) begin
               state_in = ssis_pkg::ST_WRITE;
            end
         end
         ssis_pkg::ST_WRITE: begin
            state_in = ssis_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssis_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, table port and response register control.
   always_comb begin
      key_in        = key_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      sh_in         = sh_ff;
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rd_addr       = IDX_W'(pos_next);
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(sh_ff);
      wr_data       = rd_data_ff;
      case (state_ff)
         ssis_pkg::ST_IDLE: begin
            if (req_xfer) begin
               key_in  = req_chan.value;
               cmd_in  = req_chan.cmd;
               pos_in  = '0;
               rd_addr = '0;
            end
         end
         ssis_pkg::ST_SCAN: begin
            if (!scan_stop) begin
               pos_in  = pos_next;
               rd_addr = IDX_W'(pos_next);
            end else if (do_insert) begin
               // Start the move at the top: read the last entry, write it one place up.
               sh_in   = count_ff;
               rd_addr = IDX_W'(count_dec);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_count_in = count_ff;
               if (cmd_ff == ssis_pkg::CMD_SEARCH) begin
                  rsp_status_in = present ? ssis_pkg::STATUS_HIT : ssis_pkg::STATUS_MISS;
               end else if (present) begin
                  rsp_status_in = ssis_pkg::STATUS_MISS;
               end else begin
                  rsp_status_in = ssis_pkg::STATUS_FULL;
               end
            end
         end
         ssis_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(sh_ff);
            wr_data = rd_data_ff;
            sh_in   = sh_dec;
            rd_addr = IDX_W'(sh_dec2);
         end
         ssis_pkg::ST_WRITE: begin
            wr_en         = 1'b1;
            wr_addr       = IDX_W'(pos_ff);
            wr_data       = key_ff;
            count_in      = count_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ssis_pkg::STATUS_HIT;
            rsp_pos_in    = pos_ff;
            rsp_count_in  = count_ff + CNT_W'(1);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssis_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      sh_ff         <= sh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Table with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign req_chan.ready       = (state_ff == ssis_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.position    = ssis_pkg::POS_W'(rsp_pos_ff);
   assign rsp_chan.entry_count = ssis_pkg::POS_W'(rsp_count_ff);

   `ASSERT_CLK(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count exceeds capacity")
   `ASSERT_IMPLY(a_shift_above_pos, state_ff == ssis_pkg::ST_SHIFT,
                 sh_ff > pos_ff && sh_ff <= count_ff, "shift index outside the moved range")
   `ASSERT_IMPLY(a_rsp_from_busy, $rose(rsp_valid_ff),
                 $past(state_ff) == ssis_pkg::ST_SCAN || $past(state_ff) == ssis_pkg::ST_WRITE,
                 "response raised outside scan or write")
   `ASSERT_IMPLY(a_insert_grows, $past(state_ff) == ssis_pkg::ST_WRITE,
                 count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the count")

endmodule
